// ===== src/bsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bus shadow memory checker package
// Shared types, status codes and register map for the checker core.
// ----------------------------------------------------------------------------
package bsmc_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam int          PADDR_W           = 3;
  localparam logic [31:0] IGNORE_BASE_RESET = 32'hF000_0000;

  localparam logic [PADDR_W-1:0] ADDR_IGNORE_BASE = 3'd0;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_MISMATCH = 3'd1;
  localparam status_t ST_MISS     = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_IGNORED  = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [31:0] address;
    logic [31:0] bus_data;
    logic [3:0]  byte_enable;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] expected_data;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic word_finish;
    logic miss_finish;
    logic ignore_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic ignored;
    logic hit;
    logic miss;
    logic rsp_free;
  } dp_stat_t;

  function automatic logic [31:0] lane_mask(input logic [3:0] be);
    return {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
  endfunction

endpackage

// ===== src/bus_shadow_memory_checker_core.sv =====
// ----------------------------------------------------------------------------
// Bus shadow memory checker core
// Keeps a shadow table of written words and checks observed reads against it.
// ----------------------------------------------------------------------------
// Sequence: the request is registered at the accepting edge; an ignored one is
// answered from the start state, others after the tag scan and a word read or miss.
// Requests: one at a time, the next accepted in the cycle after the response is
// loaded; a stalled response output holds back the loading of the response.
// Reset clears the entry count and control state and sets the ignore bound to
// 0xF0000000; table contents are not cleared, entries are read only once allocated.
// ----------------------------------------------------------------------------
module bus_shadow_memory_checker_core
  import bsmc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  req_t               req,
  input  logic               req_valid,
  output logic               req_stall,
  output rsp_t               rsp,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;

  assign pready    = 1'b1;
  assign req_stall = busy;

  bsmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  bsmc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

endmodule

// ===== src/bsmc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bsmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Checker controller
// Sequences accept, table scan, word access and response per request.
// ----------------------------------------------------------------------------
module bsmc_ctrl
  import bsmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_START   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_WORD_RD = 6'b001000,
    S_WORD    = 6'b010000,
    S_MISS    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.ignored) begin
          if (stat.rsp_free) begin
            cmd.ignore_finish = 1'b1;
            state_next        = S_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          state_next = S_WORD_RD;
        end else if (stat.miss) begin
          state_next = S_MISS;
        end
      end
      S_WORD_RD: begin
        state_next = S_WORD;
      end
      S_WORD: begin
        if (stat.rsp_free) begin
          cmd.word_finish = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_MISS: begin
        if (stat.rsp_free) begin
          cmd.miss_finish = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== src/bsmc_datapath.sv =====
// ----------------------------------------------------------------------------
// Checker datapath
// Holds the request, the tag and word memories, the scan counters, the
// ignore bound register and the response register.
// ----------------------------------------------------------------------------
module bsmc_datapath
  import bsmc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  req_t               req,
  output rsp_t               rsp,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  req_t          req_q;
  logic [31:0]   ignore_base;
  logic [CW-1:0] used;
  logic [CW-1:0] k;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic [AW-1:0] hit_idx;
  rsp_t          rsp_q;

  logic [31:0] tag_rdata;
  logic [31:0] word_rdata;
  logic [31:0] mask;
  logic        is_write;
  logic        full;
  logic        hit;
  logic        issue;
  logic        alloc;
  logic        tag_we;
  logic        word_we;
  logic [AW-1:0] word_waddr;
  logic [31:0] word_wdata;
  logic        rsp_free;
  logic        cfg_write;

  assign mask     = lane_mask(req_q.byte_enable);
  assign is_write = (req_q.cmd == CMD_WRITE);
  assign full     = (used == CW'(ENTRIES));
  assign hit      = cmp_valid && (tag_rdata == req_q.address);
  assign issue    = (k < used);
  assign rsp_free = !rsp_valid || !rsp_stall;

  assign alloc      = cmd.miss_finish && is_write && !full;
  assign tag_we     = alloc;
  assign word_we    = alloc || (cmd.word_finish && is_write);
  assign word_waddr = alloc ? used[AW-1:0] : hit_idx;
  assign word_wdata = alloc ? (req_q.bus_data & mask)
                            : ((word_rdata & ~mask) | (req_q.bus_data & mask));

  assign stat.ignored  = (req_q.address >= ignore_base);
  assign stat.hit      = hit;
  assign stat.miss     = !cmp_valid && !issue;
  assign stat.rsp_free = rsp_free;

  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_IGNORE_BASE);
  assign prdata    = (paddr == ADDR_IGNORE_BASE) ? ignore_base : 32'd0;

  bsmc_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (used[AW-1:0]),
    .wdata (req_q.address),
    .raddr (k[AW-1:0]),
    .rdata (tag_rdata)
  );

  bsmc_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .raddr (hit_idx),
    .rdata (word_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.scan_step && hit) begin
      hit_idx <= cmp_idx;
    end
    if (cmd.scan_step && !hit) begin
      cmp_idx <= k[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_base <= IGNORE_BASE_RESET;
      used        <= '0;
      k           <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        ignore_base <= pwdata;
      end
      if (alloc) begin
        used <= used + CW'(1);
      end
      if (cmd.scan_start) begin
        k         <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        if (hit) begin
          cmp_valid <= 1'b0;
        end else begin
          cmp_valid <= issue;
          if (issue) begin
            k <= k + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ignore_finish) begin
      rsp_q.status        <= ST_IGNORED;
      rsp_q.expected_data <= 32'd0;
    end else if (cmd.miss_finish) begin
      rsp_q.expected_data <= 32'd0;
      if (!is_write) begin
        rsp_q.status <= ST_MISS;
      end else if (full) begin
        rsp_q.status <= ST_FULL;
      end else begin
        rsp_q.status <= ST_OK;
      end
    end else if (cmd.word_finish) begin
      if (!is_write && (word_rdata != req_q.bus_data)) begin
        rsp_q.status        <= ST_MISMATCH;
        rsp_q.expected_data <= word_rdata;
      end else begin
        rsp_q.status        <= ST_OK;
        rsp_q.expected_data <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.ignore_finish || cmd.miss_finish || cmd.word_finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp = rsp_q;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(ENTRIES))
    else $error("entry count exceeds table size");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    alloc |=> used == $past(used) + CW'(1))
    else $error("allocation did not advance entry count");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.word_finish |-> CW'(hit_idx) < used)
    else $error("word access outside allocated entries");

  a_expect_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_q.status == ST_MISMATCH || rsp_q.expected_data == 32'd0))
    else $error("expected data set without a mismatch");

endmodule
